// ===== design/cna_pkg.sv =====
// Shared command codes and control type for the complex arithmetic unit.
package cna_pkg;

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_SUB      = 3'd1;
   localparam logic [2:0] CMD_MUL      = 3'd2;
   localparam logic [2:0] CMD_SCALE    = 3'd3;
   localparam logic [2:0] CMD_DIVIDE   = 3'd4;
   localparam logic [2:0] CMD_EQUAL    = 3'd5;
   localparam logic [2:0] CMD_MAG_LESS = 3'd6;

   // control that rides alongside the data path
   typedef struct packed {
      logic is_div;
      logic neg_real;
      logic neg_imag;
      logic compare_true;
      logic overflowed;
      logic divide_by_zero;
   } ctl_type;

endpackage

// ===== design/complex_number_alu.sv =====
// Complex arithmetic unit top level: front stages, divide pipeline, output stage.
// Path from accepted beat to result beat:
//   three front stages, WORD_BITS + 2 restoring divide steps, one output stage.
// Throughput: one beat per cycle unless the output stalls; every command takes the same path length,
//   so results leave in order. A stalled output freezes the whole pipeline.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module complex_number_alu import cna_pkg::*; #(
   parameter int WORD_BITS     = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_real, a_imag, b_real, b_imag from the lowest bit up, zero padded
   input  logic [((4*WORD_BITS+7)/8)*8-1:0]       req_tdata,
   // command
   input  logic [2:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // res_real, res_imag from the lowest bit up, zero padded
   output logic [((2*WORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // compare_true, overflowed, divide_by_zero from the lowest bit up
   output logic [2:0]                             rsp_tuser
);
   localparam int W      = WORD_BITS;
   localparam int DW     = 2 * W;
   localparam int RW     = 3 * W + FRACTION_BITS + 2;
   localparam int QW     = W + 2;
   localparam int D      = W + 2;
   localparam int OUT_DW = ((2*W+7)/8)*8;
   localparam logic [QW-1:0] POS_LIM = {3'b000, {(W-1){1'b1}}};
   localparam logic [QW-1:0] NEG_LIM = {2'b00, 1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  RES_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  RES_MIN = {1'b1, {(W-1){1'b0}}};

   // global advance: move everything whenever the output slot is free or drains
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic          f_valid;
   ctl_type       f_ctl;
   logic [W-1:0]  f_real, f_imag;
   logic [RW-1:0] f_num_r, f_num_i;
   logic [DW-1:0] f_den;

   cna_front #(
      .WORD_BITS    (WORD_BITS),
      .FRACTION_BITS(FRACTION_BITS),
      .RW           (RW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .cmd      (req_tuser),
      .a_re     ($signed(req_tdata[W-1:0])),
      .a_im     ($signed(req_tdata[2*W-1:W])),
      .b_re     ($signed(req_tdata[3*W-1:2*W])),
      .b_im     ($signed(req_tdata[4*W-1:3*W])),
      .out_valid(f_valid),
      .out_ctl  (f_ctl),
      .out_real (f_real),
      .out_imag (f_imag),
      .num_real (f_num_r),
      .num_imag (f_num_i),
      .den      (f_den)
   );

   // divide pipeline, one quotient bit per stage from the top down
   logic [RW-1:0] rem_r_w [D+1];
   logic [RW-1:0] rem_i_w [D+1];
   logic [QW-1:0] q_r_w   [D+1];
   logic [QW-1:0] q_i_w   [D+1];
   logic [DW-1:0] den_w   [D+1];

   assign rem_r_w[0] = f_num_r;
   assign rem_i_w[0] = f_num_i;
   assign q_r_w[0]   = '0;
   assign q_i_w[0]   = '0;
   assign den_w[0]   = f_den;

   for (genvar j = 0; j < D; j++) begin : g_div
      cna_div_stage #(
         .RW(RW),
         .DW(DW),
         .QW(QW),
         .K (D - 1 - j)
      ) u_step (
         .clock   (clock),
         .en      (en),
         .rem_r_in(rem_r_w[j]),
         .rem_i_in(rem_i_w[j]),
         .q_r_in  (q_r_w[j]),
         .q_i_in  (q_i_w[j]),
         .den_in  (den_w[j]),
         .rem_r   (rem_r_w[j+1]),
         .rem_i   (rem_i_w[j+1]),
         .q_r     (q_r_w[j+1]),
         .q_i     (q_i_w[j+1]),
         .den     (den_w[j+1])
      );
   end

   // hold control, non-divide results and valid bits alongside the divider
   logic         vd_ff  [D];
   ctl_type      ctl_ff [D];
   logic [W-1:0] rr_ff  [D];
   logic [W-1:0] ri_ff  [D];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) vd_ff[i] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= f_valid;
         for (int i = 1; i < D; i++) vd_ff[i] <= vd_ff[i-1];
      end
      if (en) begin
         ctl_ff[0] <= f_ctl;
         rr_ff[0]  <= f_real;
         ri_ff[0]  <= f_imag;
         for (int i = 1; i < D; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
            rr_ff[i]  <= rr_ff[i-1];
            ri_ff[i]  <= ri_ff[i-1];
         end
      end
   end

   // output stage: apply sign and saturation to quotients, select result
   ctl_type      c_last;
   logic [QW-1:0] qr, qi, nqr, nqi;
   logic [W-1:0] res_r_in, res_i_in;
   logic         ovf_r, ovf_i;
   logic [2:0]   flags_in;

   always_comb begin
      c_last = ctl_ff[D-1];
      qr     = q_r_w[D];
      qi     = q_i_w[D];
      nqr    = QW'(0) - qr;
      nqi    = QW'(0) - qi;
      ovf_r  = 1'b0;
      ovf_i  = 1'b0;
      if (c_last.neg_real) begin
         ovf_r    = qr > NEG_LIM;
         res_r_in = ovf_r ? RES_MIN : nqr[W-1:0];
      end else begin
         ovf_r    = qr > POS_LIM;
         res_r_in = ovf_r ? RES_MAX : qr[W-1:0];
      end
      if (c_last.neg_imag) begin
         ovf_i    = qi > NEG_LIM;
         res_i_in = ovf_i ? RES_MIN : nqi[W-1:0];
      end else begin
         ovf_i    = qi > POS_LIM;
         res_i_in = ovf_i ? RES_MAX : qi[W-1:0];
      end
      flags_in = {1'b0, c_last.overflowed, c_last.compare_true};
      priority if (c_last.is_div && c_last.divide_by_zero) begin
         res_r_in = '0;
         res_i_in = '0;
         flags_in = 3'b100;
      end else if (c_last.is_div) begin
         flags_in = {1'b0, ovf_r || ovf_i, 1'b0};
      end else begin
         res_r_in = rr_ff[D-1];
         res_i_in = ri_ff[D-1];
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] rsp_r_ff, rsp_i_ff;
   logic [2:0]   rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_ff[D-1];
      end
      if (en) begin
         rsp_r_ff     <= res_r_in;
         rsp_i_ff     <= res_i_in;
         rsp_flags_ff <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_i_ff, rsp_r_ff});
   assign rsp_tuser  = rsp_flags_ff;

   // a divide by zero beat carries zero data and no overflow
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata[2*W-1:0] == '0 && !rsp_tuser[1])
      else $error("divide by zero beat carries data or overflow");

   // a true compare carries zero data and no other flag
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[2*W-1:0] == '0 && rsp_tuser[2:1] == 2'b00)
      else $error("compare beat carries data or flags");

   // a stall freezes the divide pipeline occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vd_ff[D-1]) && $stable(vd_ff[0]) && $stable(rsp_valid_ff))
      else $error("pipeline moved during stall");

   // front output valid lands in the first divide stage on advance
   a_advance: assert property (@(posedge clock) disable iff (reset)
      en |=> vd_ff[0] == $past(f_valid))
      else $error("valid bit lost on advance");

endmodule

// ===== design/cna_front.sv =====
// Front stages: products, sums, shift/saturate and divide operand setup.
module cna_front import cna_pkg::*; #(
   parameter int WORD_BITS     = 16,
   parameter int FRACTION_BITS = 8,
   parameter int RW            = 58
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [2:0]                  cmd,
   input  logic signed [WORD_BITS-1:0] a_re,
   input  logic signed [WORD_BITS-1:0] a_im,
   input  logic signed [WORD_BITS-1:0] b_re,
   input  logic signed [WORD_BITS-1:0] b_im,
   output logic                        out_valid,
   output ctl_type                     out_ctl,
   output logic [WORD_BITS-1:0]        out_real,
   output logic [WORD_BITS-1:0]        out_imag,
   output logic [RW-1:0]               num_real,
   output logic [RW-1:0]               num_imag,
   output logic [2*WORD_BITS-1:0]      den
);
   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 2;
   localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   // stage 1: products
   logic                 v1_ff;
   logic [2:0]           cmd1_ff;
   logic signed [W-1:0]  a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [PW-1:0] ac1_ff, bd1_ff, ad1_ff, bc1_ff, aa1_ff, bb1_ff, cc1_ff, dd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         cmd1_ff <= cmd;
         a1_ff   <= a_re;
         b1_ff   <= a_im;
         c1_ff   <= b_re;
         d1_ff   <= b_im;
         ac1_ff  <= a_re * b_re;
         bd1_ff  <= a_im * b_im;
         ad1_ff  <= a_re * b_im;
         bc1_ff  <= a_im * b_re;
         aa1_ff  <= a_re * a_re;
         bb1_ff  <= a_im * a_im;
         cc1_ff  <= b_re * b_re;
         dd1_ff  <= b_im * b_im;
      end
   end

   // stage 2: sums per command
   logic                 v2_ff;
   logic [2:0]           cmd2_ff;
   logic signed [SW-1:0] sr2_ff, si2_ff, sr2_in, si2_in;
   logic                 cmp2_ff, cmp2_in;
   logic [PW-1:0]        den2_ff, den2_in;
   logic [PW-1:0]        mag_a, sq_a, sq_b, sq_c, sq_d;

   always_comb begin
      sq_a    = aa1_ff;
      sq_b    = bb1_ff;
      sq_c    = cc1_ff;
      sq_d    = dd1_ff;
      mag_a   = sq_a + sq_b;
      den2_in = sq_c + sq_d;
      sr2_in  = '0;
      si2_in  = '0;
      cmp2_in = 1'b0;
      unique case (cmd1_ff)
         CMD_ADD: begin
            sr2_in = SW'(a1_ff) + SW'(c1_ff);
            si2_in = SW'(b1_ff) + SW'(d1_ff);
         end
         CMD_SUB: begin
            sr2_in = SW'(a1_ff) - SW'(c1_ff);
            si2_in = SW'(b1_ff) - SW'(d1_ff);
         end
         CMD_MUL: begin
            sr2_in = SW'(ac1_ff) - SW'(bd1_ff);
            si2_in = SW'(ad1_ff) + SW'(bc1_ff);
         end
         CMD_SCALE: begin
            sr2_in = SW'(ac1_ff);
            si2_in = SW'(bc1_ff);
         end
         CMD_DIVIDE: begin
            sr2_in = SW'(ac1_ff) + SW'(bd1_ff);
            si2_in = SW'(bc1_ff) - SW'(ad1_ff);
         end
         CMD_EQUAL:    cmp2_in = (a1_ff == c1_ff) && (b1_ff == d1_ff);
         CMD_MAG_LESS: cmp2_in = mag_a < den2_in;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         cmd2_ff <= cmd1_ff;
         sr2_ff  <= sr2_in;
         si2_ff  <= si2_in;
         cmp2_ff <= cmp2_in;
         den2_ff <= den2_in;
      end
   end

   // stage 3: shift and saturate, divide operand magnitudes
   function automatic logic [W:0] saturate(input logic signed [SW-1:0] v);
      logic [W:0] r;
      if (v > SAT_MAX)      r = {1'b1, SAT_MAX[W-1:0]};
      else if (v < SAT_MIN) r = {1'b1, SAT_MIN[W-1:0]};
      else                  r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   logic                 v3_ff;
   ctl_type              ctl3_ff, ctl3_in;
   logic [W-1:0]         rr3_ff, ri3_ff;
   logic [RW-1:0]        nr3_ff, ni3_ff, nr3_in, ni3_in;
   logic [PW-1:0]        den3_ff;
   logic signed [SW-1:0] shr, shi, abs_r, abs_i;
   logic [W:0]           sat_r, sat_i;
   logic                 is_div, do_shift;

   always_comb begin
      is_div   = (cmd2_ff == CMD_DIVIDE);
      do_shift = (cmd2_ff == CMD_MUL) || (cmd2_ff == CMD_SCALE);
      shr      = do_shift ? (sr2_ff >>> FRACTION_BITS) : sr2_ff;
      shi      = do_shift ? (si2_ff >>> FRACTION_BITS) : si2_ff;
      sat_r    = saturate(shr);
      sat_i    = saturate(shi);
      abs_r    = sr2_ff[SW-1] ? -sr2_ff : sr2_ff;
      abs_i    = si2_ff[SW-1] ? -si2_ff : si2_ff;
      nr3_in   = RW'($unsigned(abs_r)) << FRACTION_BITS;
      ni3_in   = RW'($unsigned(abs_i)) << FRACTION_BITS;
      ctl3_in.is_div         = is_div;
      ctl3_in.neg_real       = sr2_ff[SW-1];
      ctl3_in.neg_imag       = si2_ff[SW-1];
      ctl3_in.compare_true   = cmp2_ff;
      ctl3_in.overflowed     = !is_div && (sat_r[W] || sat_i[W]);
      ctl3_in.divide_by_zero = is_div && (den2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         ctl3_ff <= ctl3_in;
         rr3_ff  <= sat_r[W-1:0];
         ri3_ff  <= sat_i[W-1:0];
         nr3_ff  <= nr3_in;
         ni3_ff  <= ni3_in;
         den3_ff <= den2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctl   = ctl3_ff;
   assign out_real  = rr3_ff;
   assign out_imag  = ri3_ff;
   assign num_real  = nr3_ff;
   assign num_imag  = ni3_ff;
   assign den       = den3_ff;

endmodule

// ===== design/cna_div_stage.sv =====
// One restoring divide step for both quotient lanes, registered.
module cna_div_stage #(
   parameter int RW = 58,
   parameter int DW = 32,
   parameter int QW = 18,
   parameter int K  = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] rem_r_in,
   input  logic [RW-1:0] rem_i_in,
   input  logic [QW-1:0] q_r_in,
   input  logic [QW-1:0] q_i_in,
   input  logic [DW-1:0] den_in,
   output logic [RW-1:0] rem_r,
   output logic [RW-1:0] rem_i,
   output logic [QW-1:0] q_r,
   output logic [QW-1:0] q_i,
   output logic [DW-1:0] den
);
   logic [RW-1:0] dsh;
   logic [RW-1:0] rem_r_ff, rem_i_ff, rem_r_nx, rem_i_nx;
   logic [QW-1:0] q_r_ff, q_i_ff, q_r_nx, q_i_nx;
   logic [DW-1:0] den_ff;

   always_comb begin
      dsh      = RW'(den_in) << K;
      rem_r_nx = rem_r_in;
      rem_i_nx = rem_i_in;
      q_r_nx   = q_r_in;
      q_i_nx   = q_i_in;
      if (rem_r_in >= dsh) begin
         rem_r_nx  = rem_r_in - dsh;
         q_r_nx[K] = 1'b1;
      end
      if (rem_i_in >= dsh) begin
         rem_i_nx  = rem_i_in - dsh;
         q_i_nx[K] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_r_ff <= rem_r_nx;
         rem_i_ff <= rem_i_nx;
         q_r_ff   <= q_r_nx;
         q_i_ff   <= q_i_nx;
         den_ff   <= den_in;
      end
   end

   assign rem_r = rem_r_ff;
   assign rem_i = rem_i_ff;
   assign q_r   = q_r_ff;
   assign q_i   = q_i_ff;
   assign den   = den_ff;

endmodule
